// ===== rtl/core/rmf_pkg.sv =====
// Shared types, constants and the three-value sort function of the RGB median filter.
`default_nettype none

package rmf_pkg;

    // Window geometry. The compare network in rmf_median is built for a 3x3 window.
    localparam int MED       = 3;
    localparam int RAD       = MED / 2;
    localparam int RING_ROWS = MED + RAD;
    localparam int MAX_WIDTH = 2048;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int ROW_W    = HEIGHT_W;
    localparam int LANE_W   = $clog2(RING_ROWS);
    localparam int GAP_W    = $clog2(RAD * MAX_WIDTH + RAD + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HEIGHT_W;

    // Command codes of an input word.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    typedef logic [7:0]  chan_t;
    typedef logic [23:0] pixel_t;
    typedef logic [RING_ROWS-1:0][23:0] line_col_t;

    typedef struct packed {
        chan_t lo;
        chan_t mid;
        chan_t hi;
    } trio_t;

    // Request from the position control to the line memory and window stage.
    typedef struct packed {
        logic                          we;
        logic [LANE_W-1:0]             wlane;
        logic [COL_W-1:0]              wcol;
        pixel_t                        wdata;
        logic                          emit;
        logic [COL_W-1:0]              col_a;
        logic [COL_W-1:0]              col_b;
        logic [MED-1:0][LANE_W-1:0]    lanes;
        logic                          first;
        logic                          last;
    } rmf_req_t;

    // Sorts three channel values.
    function automatic trio_t sort3(input chan_t a, input chan_t b, input chan_t c);
        chan_t l0;
        chan_t h0;
        chan_t m;
        trio_t r;
        l0    = (a < b) ? a : b;
        h0    = (a < b) ? b : a;
        r.hi  = (h0 > c) ? h0 : c;
        m     = (h0 > c) ? c : h0;
        r.lo  = (l0 < m) ? l0 : m;
        r.mid = (l0 < m) ? m : l0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rmf_if.sv =====
// Stream interfaces for the input pixel words and the filtered result words.
`default_nettype none

interface rmf_in_if import rmf_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;

    modport source(output valid, output cmd, output in_red, output in_green,
                   output in_blue, input ready);
    modport sink(input valid, input cmd, input in_red, input in_green,
                 input in_blue, output ready);
endinterface

interface rmf_out_if import rmf_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    logic  frame_last;

    modport source(output valid, output out_red, output out_green, output out_blue,
                   output frame_last, input ready);
    modport sink(input valid, input out_red, input out_green, input out_blue,
                 input frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rmf_ctrl.sv =====
// Frame position counters, configuration registers and line memory requests.
`default_nettype none

module rmf_ctrl import rmf_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  accept,
    input  wire logic                  cmd,
    input  wire pixel_t                pixel,
    output rmf_req_t                   req
);

    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0]    in_row_reg, in_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;
    logic [GAP_W-1:0]    gap_reg, gap_next;

    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
    logic [GAP_W-1:0]    delay;
    logic [COL_W-1:0]    w_last;
    logic [ROW_W-1:0]    h_last;
    logic                complete;
    logic                ox_end;
    logic                oy_end;
    logic [ROW_W-1:0]    row_top;
    logic [ROW_W-1:0]    row_bot;
    logic [WIDTH_W-1:0]  in_col_inc;
    logic [WIDTH_W-1:0]  out_col_inc;

    // Effective frame size: zero acts as one, width saturates at the line length.
    always_comb
    begin
        if (width_reg == '0)
            w = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            w = WIDTH_W'(MAX_WIDTH);
        else
            w = width_reg;
        h      = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
        delay  = GAP_W'(RAD) * GAP_W'(w) + GAP_W'(RAD);
        w_last = COL_W'(w - 1'b1);
        h_last = ROW_W'(h - 1'b1);
    end

    // Request for the current word: pixel write and window read columns and rows.
    always_comb
    begin
        complete  = (in_row_reg >= h);
        ox_end    = (out_col_reg == w_last);
        oy_end    = (out_row_reg == h_last);
        row_top   = (out_row_reg == '0) ? out_row_reg : out_row_reg - 1'b1;
        row_bot   = oy_end ? out_row_reg : out_row_reg + 1'b1;

        req.we    = accept && !complete && (cmd == CMD_PIXEL);
        req.wlane = LANE_W'(in_row_reg % RING_ROWS);
        req.wcol  = in_col_reg;
        req.wdata = pixel;
        req.emit  = accept && (complete || (req.we && (gap_reg >= delay)));
        req.col_a = ox_end ? out_col_reg : out_col_reg + 1'b1;
        req.col_b = out_col_reg;
        req.lanes[0] = LANE_W'(row_top % RING_ROWS);
        req.lanes[1] = LANE_W'(out_row_reg % RING_ROWS);
        req.lanes[2] = LANE_W'(row_bot % RING_ROWS);
        req.first = (out_col_reg == '0);
        req.last  = ox_end && oy_end;
    end

    // Next values of the registers and counters.
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        gap_next     = gap_reg;
        in_col_inc   = WIDTH_W'(in_col_reg) + 1'b1;
        out_col_inc  = WIDTH_W'(out_col_reg) + 1'b1;

        if (cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT)))
        begin
            if (cfg_index == REG_WIDTH)
                width_next = cfg_data[WIDTH_W-1:0];
            else
                height_next = cfg_data;
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            gap_next     = '0;
        end
        else if (accept)
        begin
            if (req.we)
            begin
                if (in_col_inc >= w)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = COL_W'(in_col_inc);
                end
            end
            if (req.we && !req.emit)
                gap_next = gap_reg + 1'b1;
            else if (!req.we && req.emit)
                gap_next = gap_reg - 1'b1;
            if (req.emit)
            begin
                if (req.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    gap_next     = '0;
                end
                else if (out_col_inc >= w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = COL_W'(out_col_inc);
                end
            end
        end
    end

    // Register update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_W'(640);
            height_reg  <= HEIGHT_W'(480);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            gap_reg     <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            gap_reg     <= gap_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rmf_line_mem.sv =====
// Line memory: one entry per column holding all ring rows, two read ports, write bypass.
`default_nettype none

module rmf_line_mem import rmf_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [LANE_W-1:0] wlane,
    input  wire logic [COL_W-1:0]  wcol,
    input  wire pixel_t            wdata,
    input  wire logic [COL_W-1:0]  col_a,
    input  wire logic [COL_W-1:0]  col_b,
    output line_col_t              rd_a,
    output line_col_t              rd_b
);

    line_col_t mem [MAX_WIDTH];

    line_col_t          rd_a_reg;
    line_col_t          rd_b_reg;
    logic [COL_W-1:0]   col_a_reg;
    logic [COL_W-1:0]   col_b_reg;
    logic               fwd_we_reg;
    logic [LANE_W-1:0]  fwd_lane_reg;
    logic [COL_W-1:0]   fwd_col_reg;
    pixel_t             fwd_data_reg;

    // Lane write and registered reads; the reads hold while the pipeline stalls.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wcol][wlane] <= wdata;
        if (en)
        begin
            rd_a_reg     <= mem[col_a];
            rd_b_reg     <= mem[col_b];
            col_a_reg    <= col_a;
            col_b_reg    <= col_b;
            fwd_lane_reg <= wlane;
            fwd_col_reg  <= wcol;
            fwd_data_reg <= wdata;
        end
    end

    // The write valid flag of the bypass is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_we_reg <= 1'b0;
        else if (en)
            fwd_we_reg <= we;
    end

    // A write in the read cycle is not seen by the array read, so it is patched in here.
    always_comb
    begin
        rd_a = rd_a_reg;
        rd_b = rd_b_reg;
        if (fwd_we_reg && (fwd_col_reg == col_a_reg))
            rd_a[fwd_lane_reg] = fwd_data_reg;
        if (fwd_we_reg && (fwd_col_reg == col_b_reg))
            rd_b[fwd_lane_reg] = fwd_data_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rmf_median.sv =====
// Two-stage 3x3 median network per color channel with the output register.
`default_nettype none

module rmf_median import rmf_pkg::*; (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       vin,
    input  wire logic                       last_in,
    input  wire pixel_t [MED-1:0][MED-1:0]  win,
    output logic                            valid,
    output chan_t                           red,
    output chan_t                           green,
    output chan_t                           blue,
    output logic                            last
);

    trio_t [MED-1:0][2:0] srt;
    trio_t [MED-1:0][2:0] srt_reg;
    logic                 v_a_reg;
    logic                 last_a_reg;
    chan_t [2:0]          med;
    chan_t [2:0]          med_reg;
    logic                 valid_reg;
    logic                 last_reg;
    trio_t [2:0]          lo_s;
    trio_t [2:0]          mid_s;
    trio_t [2:0]          hi_s;
    trio_t [2:0]          fin_s;

    // First stage: sort each window column, channel by channel.
    always_comb
    begin
        for (int c = 0; c < MED; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                srt[c][k] = sort3(win[c][0][k*8 +: 8], win[c][1][k*8 +: 8],
                                  win[c][2][k*8 +: 8]);
            end
        end
    end

    // Second stage: largest low, middle of middles, smallest high, then their median.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_s[k]  = sort3(srt_reg[0][k].lo, srt_reg[1][k].lo, srt_reg[2][k].lo);
            mid_s[k] = sort3(srt_reg[0][k].mid, srt_reg[1][k].mid, srt_reg[2][k].mid);
            hi_s[k]  = sort3(srt_reg[0][k].hi, srt_reg[1][k].hi, srt_reg[2][k].hi);
            fin_s[k] = sort3(lo_s[k].hi, mid_s[k].mid, hi_s[k].lo);
            med[k]   = fin_s[k].mid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srt_reg    <= srt;
            last_a_reg <= last_in;
            med_reg    <= med;
            last_reg   <= last_a_reg;
        end
    end

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_a_reg   <= vin;
            valid_reg <= v_a_reg;
        end
    end

    assign valid = valid_reg;
    assign red   = med_reg[2];
    assign green = med_reg[1];
    assign blue  = med_reg[0];
    assign last  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_median_filter.sv =====
// Top level of the streaming 3x3 RGB median filter.
//
//  port     | dir | word contents
//  ---------+-----+-------------------------------------------------------
//  pixels   | in  | cmd, in_red, in_green, in_blue (valid/ready)
//  medians  | out | out_red, out_green, out_blue, frame_last (valid/ready)
//  cfg_*    | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One word is accepted per cycle unless the output stalls. The word that causes a
// result passes the memory read, column sort, median select and output register.
// The line memory has one entry per column, so both window columns come from its two
// read ports in one cycle. Reset clears counters and valid flags; the memory is not
// cleared, since each window entry is written in the frame before it is read.
// A stalled output holds the whole pipeline and drops ready on the input.
`default_nettype none

module rgb_median_filter import rmf_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    rmf_in_if.sink                     pixels,
    rmf_out_if.source                  medians
);

    logic      en;
    logic      accept;
    rmf_req_t  req;
    line_col_t rd_a;
    line_col_t rd_b;

    logic                       v1_reg;
    logic                       first1_reg;
    logic                       last1_reg;
    logic [MED-1:0][LANE_W-1:0] lanes1_reg;
    pixel_t [MED-1:0]           prev_center_reg;
    pixel_t [MED-1:0][MED-1:0]  win;

    // Pipeline advances whenever the output register is free or being taken.
    assign en           = !medians.valid || medians.ready;
    assign pixels.ready = en;
    assign accept       = pixels.valid && en;

    rmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (pixels.cmd),
        .pixel     ({pixels.in_red, pixels.in_green, pixels.in_blue}),
        .req       (req)
    );

    rmf_line_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .we    (req.we),
        .wlane (req.wlane),
        .wcol  (req.wcol),
        .wdata (req.wdata),
        .col_a (req.col_a),
        .col_b (req.col_b),
        .rd_a  (rd_a),
        .rd_b  (rd_b)
    );

    // Window stage control follows the memory read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            first1_reg <= req.first;
            last1_reg  <= req.last;
            lanes1_reg <= req.lanes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= req.emit;
    end

    // Window columns: left is the previous center, or the center at a row start.
    always_comb
    begin
        for (int r = 0; r < MED; r++)
        begin
            win[1][r] = rd_b[lanes1_reg[r]];
            win[2][r] = rd_a[lanes1_reg[r]];
            win[0][r] = first1_reg ? rd_b[lanes1_reg[r]] : prev_center_reg[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && v1_reg)
            prev_center_reg <= win[1];
    end

    rmf_median u_median (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vin     (v1_reg),
        .last_in (last1_reg),
        .win     (win),
        .valid   (medians.valid),
        .red     (medians.out_red),
        .green   (medians.out_green),
        .blue    (medians.out_blue),
        .last    (medians.frame_last)
    );

    // A memory write only happens for an accepted word.
    a_we_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> accept)
        else $error("line memory written without an accepted word");

    // A result request reaches the window stage in the next cycle.
    a_emit_stage: assert property (@(posedge clk) disable iff (!rst_n)
        req.emit |=> v1_reg)
        else $error("result request lost before the window stage");

    // The window stage holds its word while the output is stalled.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en) |=> (v1_reg && $stable(last1_reg)))
        else $error("window stage changed during a stall");

endmodule

`default_nettype wire
